// ===== rtl/cda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg: types, constants and control store for the calendar date unit
// Microcode program, control word layout, status codes and calendar helpers.
// ----------------------------------------------------------------------------
package cda_pkg;

	localparam int PC_W = 5;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	localparam logic CFG_MIN_YEAR = 1'b0;
	localparam logic CFG_MAX_YEAR = 1'b1;

	localparam logic [13:0] MIN_YEAR_RST = 14'd1980;
	localparam logic [13:0] MAX_YEAR_RST = 14'd9999;

	localparam logic [2:0]  RED_STEPS   = 3'd5;
	localparam logic [8:0]  ERA_YEARS   = 9'd400;
	localparam logic [21:0] DAYS_PER_ERA = 22'd146097;

	typedef enum logic [3:0] {
		A_NOP,
		A_RED,
		A_CINIT,
		A_MSTEP,
		A_YSTEP,
		A_ERA,
		A_MFIRST,
		A_AYEAR,
		A_AMON,
		A_SETD,
		A_ADDD,
		A_FOK,
		A_FBAD,
		A_FOVF
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_K_NZ,
		C_START_BAD,
		C_OP_ADD,
		C_TGT_BAD,
		C_NOT_LATER,
		C_YM_EQ,
		C_JAN_BEFORE,
		C_ERA_OK,
		C_Y_EQ,
		C_FITS,
		C_YEAR_FITS,
		C_MON_FITS,
		C_OVF
	} cond_t;

	typedef struct packed {
		act_t            act;
		cond_t           cond;
		logic [PC_W-1:0] tgt;
	} ctrl_t;

	// program addresses
	localparam logic [PC_W-1:0] PC_RED      = 5'd0;
	localparam logic [PC_W-1:0] PC_CNT_LOOP = 5'd6;
	localparam logic [PC_W-1:0] PC_YR_LOOP  = 5'd9;
	localparam logic [PC_W-1:0] PC_YSTEP    = 5'd11;
	localparam logic [PC_W-1:0] PC_ERA      = 5'd12;
	localparam logic [PC_W-1:0] PC_ADD      = 5'd13;
	localparam logic [PC_W-1:0] PC_ADD_LOOP = 5'd15;
	localparam logic [PC_W-1:0] PC_AYEAR    = 5'd18;
	localparam logic [PC_W-1:0] PC_AMON     = 5'd19;
	localparam logic [PC_W-1:0] PC_ADDD     = 5'd20;
	localparam logic [PC_W-1:0] PC_ADD_END  = 5'd21;
	localparam logic [PC_W-1:0] PC_FOK      = 5'd22;
	localparam logic [PC_W-1:0] PC_FBAD     = 5'd23;
	localparam logic [PC_W-1:0] PC_FOVF     = 5'd24;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		case (pc)
			5'd0:  w = '{A_RED,    C_K_NZ,       PC_RED};
			5'd1:  w = '{A_NOP,    C_START_BAD,  PC_FBAD};
			5'd2:  w = '{A_NOP,    C_OP_ADD,     PC_ADD};
			5'd3:  w = '{A_NOP,    C_TGT_BAD,    PC_FBAD};
			5'd4:  w = '{A_NOP,    C_NOT_LATER,  PC_FOK};
			5'd5:  w = '{A_CINIT,  C_NEVER,      PC_RED};
			5'd6:  w = '{A_NOP,    C_YM_EQ,      PC_FOK};
			5'd7:  w = '{A_NOP,    C_JAN_BEFORE, PC_YR_LOOP};
			5'd8:  w = '{A_MSTEP,  C_ALWAYS,     PC_CNT_LOOP};
			5'd9:  w = '{A_NOP,    C_ERA_OK,     PC_ERA};
			5'd10: w = '{A_NOP,    C_Y_EQ,       PC_CNT_LOOP};
			5'd11: w = '{A_YSTEP,  C_ALWAYS,     PC_YR_LOOP};
			5'd12: w = '{A_ERA,    C_ALWAYS,     PC_YR_LOOP};
			5'd13: w = '{A_NOP,    C_FITS,       PC_ADDD};
			5'd14: w = '{A_MFIRST, C_NEVER,      PC_RED};
			5'd15: w = '{A_NOP,    C_YEAR_FITS,  PC_AYEAR};
			5'd16: w = '{A_NOP,    C_MON_FITS,   PC_AMON};
			5'd17: w = '{A_SETD,   C_ALWAYS,     PC_ADD_END};
			5'd18: w = '{A_AYEAR,  C_ALWAYS,     PC_ADD_LOOP};
			5'd19: w = '{A_AMON,   C_ALWAYS,     PC_ADD_LOOP};
			5'd20: w = '{A_ADDD,   C_NEVER,      PC_RED};
			5'd21: w = '{A_NOP,    C_OVF,        PC_FOVF};
			5'd22: w = '{A_FOK,    C_NEVER,      PC_RED};
			5'd23: w = '{A_FBAD,   C_NEVER,      PC_RED};
			5'd24: w = '{A_FOVF,   C_NEVER,      PC_RED};
			default: w = '{A_FBAD, C_NEVER,      PC_RED};
		endcase
		return w;
	endfunction

	// leap test on the year taken modulo 400
	function automatic logic leap400(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m) inside
			4'd2:                     n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default:                  n = 5'd31;
		endcase
		return n;
	endfunction

	// subtrahends for the restoring mod-400 reduction, 400 << k
	function automatic logic [13:0] red_const(input logic [2:0] k);
		return 14'({5'd0, ERA_YEARS} << k);
	endfunction

endpackage

// ===== rtl/calendar_date_add_and_difference.sv =====
// run time is set by the microcode loops: a bad start date or a bad target ends early; add
// steps whole years and months, up to about 180 years; count steps eras of 400 years, then
// single years and months
// throughput: one item at a time; a new item is taken once the previous result sits
// in the output register
// reset: asynchronous, clears the sequencer and output valid, restores year limits
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_and_difference: Gregorian date add and day count
// Microcoded sequencer stepping a start date by eras, years and months.
// ----------------------------------------------------------------------------
module calendar_date_add_and_difference (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [4:0]           day,
	input  logic [3:0]           month,
	input  logic [13:0]          year,
	input  logic [15:0]          addend,
	input  logic [4:0]           target_day,
	input  logic [3:0]           target_month,
	input  logic [13:0]          target_year,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [4:0]           out_day,
	output logic [3:0]           out_month,
	output logic [13:0]          out_year,
	output logic [21:0]          day_count,
	output logic [1:0]           status,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [13:0]          cfg_data
);
	import cda_pkg::*;

	logic                busy_q;
	logic [PC_W-1:0]     upc_q;
	logic                out_valid_q;
	logic [13:0]         min_q, max_q;

	logic                op_q;
	logic [4:0]          sd_q;
	logic [3:0]          sm_q;
	logic [13:0]         sy_q;
	logic [4:0]          d_q;
	logic [3:0]          m_q;
	logic [14:0]         cy_q;
	logic [13:0]         ym_q, tym_q;
	logic [15:0]         r_q;
	logic [4:0]          td_q;
	logic [3:0]          tm_q;
	logic [13:0]         ty_q;
	logic [21:0]         cnt_q;
	logic [2:0]          k_q;

	logic [4:0]          od_q;
	logic [3:0]          om_q;
	logic [13:0]         oy_q;
	logic [21:0]         ocnt_q;
	logic [1:0]          ost_q;

	ctrl_t               cw;
	logic                cond_hit, is_fin, fin_go, accept;
	logic                leap_cur, leap_tgt;
	logic [4:0]          ml_cur, ml_tgt;
	logic [8:0]          ylen;
	logic                start_ok, tgt_ok;
	logic [3:0]          m_adv;
	logic [14:0]         cy_adv;
	logic [13:0]         ym_inc, ym_adv;
	logic [13:0]         rc;

	assign accept   = in_valid && in_ready;
	assign in_ready = !busy_q;
	assign cw       = ucode(upc_q);

	assign leap_cur = leap400(ym_q[8:0]);
	assign leap_tgt = leap400(tym_q[8:0]);
	assign ml_cur   = month_len(m_q, leap_cur);
	assign ml_tgt   = month_len(tm_q, leap_tgt);
	assign ylen     = leap_cur ? 9'd366 : 9'd365;
	assign rc       = red_const(k_q);

	assign start_ok = (sm_q >= 4'd1) && (sm_q <= 4'd12) && (sd_q >= 5'd1) && (sd_q <= ml_cur)
		&& (sy_q >= min_q) && (sy_q <= max_q);
	assign tgt_ok   = (tm_q >= 4'd1) && (tm_q <= 4'd12) && (td_q >= 5'd1) && (td_q <= ml_tgt)
		&& (ty_q >= min_q) && (ty_q <= max_q);

	// next month, rolling the year and its mod-400 residue
	assign ym_inc = (ym_q[8:0] == ERA_YEARS - 9'd1) ? 14'd0 : ym_q + 14'd1;
	always_comb begin
		if (m_q == 4'd12) begin
			m_adv  = 4'd1;
			cy_adv = cy_q + 15'd1;
			ym_adv = ym_inc;
		end else begin
			m_adv  = m_q + 4'd1;
			cy_adv = cy_q;
			ym_adv = ym_q;
		end
	end

	always_comb begin
		unique case (cw.cond)
			C_NEVER:      cond_hit = 1'b0;
			C_ALWAYS:     cond_hit = 1'b1;
			C_K_NZ:       cond_hit = (k_q != 3'd0);
			C_START_BAD:  cond_hit = !start_ok;
			C_OP_ADD:     cond_hit = !op_q;
			C_TGT_BAD:    cond_hit = !tgt_ok;
			C_NOT_LATER:  cond_hit = ({ty_q, tm_q, td_q} <= {sy_q, sm_q, sd_q});
			C_YM_EQ:      cond_hit = (cy_q == {1'b0, ty_q}) && (m_q == tm_q);
			C_JAN_BEFORE: cond_hit = (m_q == 4'd1) && (cy_q != {1'b0, ty_q});
			C_ERA_OK:     cond_hit = ({2'b0, ty_q} >= ({1'b0, cy_q} + {7'd0, ERA_YEARS}));
			C_Y_EQ:       cond_hit = (cy_q == {1'b0, ty_q});
			C_FITS:       cond_hit = (({12'd0, d_q} + {1'b0, r_q}) <= {12'd0, ml_cur});
			C_YEAR_FITS:  cond_hit = (m_q == 4'd1) && (r_q >= {7'd0, ylen});
			C_MON_FITS:   cond_hit = (r_q >= {11'd0, ml_cur});
			C_OVF:        cond_hit = (cy_q > {1'b0, max_q});
			default:      cond_hit = 1'b0;
		endcase
	end

	assign is_fin = (cw.act == A_FOK) || (cw.act == A_FBAD) || (cw.act == A_FOVF);
	assign fin_go = busy_q && is_fin && (!out_valid_q || out_ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			upc_q       <= PC_RED;
			out_valid_q <= 1'b0;
			min_q       <= MIN_YEAR_RST;
			max_q       <= MAX_YEAR_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_YEAR) min_q <= cfg_data;
				else max_q <= cfg_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
				upc_q  <= PC_RED;
			end else if (busy_q) begin
				if (is_fin) begin
					if (fin_go) busy_q <= 1'b0;
				end else begin
					upc_q <= cond_hit ? cw.tgt : upc_q + 5'd1;
				end
			end
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			sd_q  <= day;
			sm_q  <= month;
			sy_q  <= year;
			d_q   <= day;
			m_q   <= month;
			cy_q  <= {1'b0, year};
			ym_q  <= year;
			r_q   <= addend;
			td_q  <= target_day;
			tm_q  <= target_month;
			ty_q  <= target_year;
			tym_q <= target_year;
			cnt_q <= '0;
			k_q   <= RED_STEPS;
		end else if (busy_q) begin
			case (cw.act)
				A_RED: begin
					if (ym_q >= rc) ym_q <= ym_q - rc;
					if (tym_q >= rc) tym_q <= tym_q - rc;
					k_q <= k_q - 3'd1;
				end
				A_CINIT: cnt_q <= {17'd0, td_q} - {17'd0, d_q};
				A_MSTEP: begin
					cnt_q <= cnt_q + {17'd0, ml_cur};
					m_q   <= m_adv;
					cy_q  <= cy_adv;
					ym_q  <= ym_adv;
				end
				A_YSTEP: begin
					cnt_q <= cnt_q + {13'd0, ylen};
					cy_q  <= cy_q + 15'd1;
					ym_q  <= ym_inc;
				end
				A_ERA: begin
					cnt_q <= cnt_q + DAYS_PER_ERA;
					cy_q  <= cy_q + {6'd0, ERA_YEARS};
				end
				A_MFIRST: begin
					r_q  <= 16'(({1'b0, r_q} + {12'd0, d_q}) - {12'd0, ml_cur} - 17'd1);
					d_q  <= 5'd1;
					m_q  <= m_adv;
					cy_q <= cy_adv;
					ym_q <= ym_adv;
				end
				A_AYEAR: begin
					r_q  <= r_q - {7'd0, ylen};
					cy_q <= cy_q + 15'd1;
					ym_q <= ym_inc;
				end
				A_AMON: begin
					r_q  <= r_q - {11'd0, ml_cur};
					m_q  <= m_adv;
					cy_q <= cy_adv;
					ym_q <= ym_adv;
				end
				A_SETD: d_q <= r_q[4:0] + 5'd1;
				A_ADDD: d_q <= d_q + r_q[4:0];
				default: ;
			endcase
		end
		if (fin_go) begin
			if (cw.act == A_FOK && !op_q) begin
				od_q <= d_q;
				om_q <= m_q;
				oy_q <= cy_q[13:0];
			end else begin
				od_q <= sd_q;
				om_q <= sm_q;
				oy_q <= sy_q;
			end
			ocnt_q <= (cw.act == A_FOK) ? cnt_q : '0;
			case (cw.act)
				A_FBAD:  ost_q <= ST_BAD;
				A_FOVF:  ost_q <= ST_OVF;
				default: ost_q <= ST_OK;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_day   = od_q;
	assign out_month = om_q;
	assign out_year  = oy_q;
	assign day_count = ocnt_q;
	assign status    = ost_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && upc_q == PC_RED))
		else $error("accepted item did not start the program");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && upc_q == 5'd1) |-> (ym_q < 14'd400 && tym_q < 14'd400))
		else $error("year residue not reduced below 400");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD || status == ST_OVF))
		else $error("undefined status code");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (day_count == 22'd0))
		else $error("nonzero day count on failed item");

	a_no_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (!busy_q && out_valid))
		else $error("result transfer did not free the sequencer");

endmodule

// ===== dv/calendar_date_add_and_difference_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_and_difference_checker: date unit scoreboard
// Watches the year-limit writes and both transfer channels, works out the
// Gregorian result of every accepted request and compares it field by field
// with the results as they leave the block, oldest first.
// ----------------------------------------------------------------------------
package date_op_pkg;

	typedef enum logic {
		OP_ADD_DAYS,
		OP_COUNT_DAYS
	} date_op_t;

endpackage

module calendar_date_add_and_difference_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        op,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	input  logic [15:0] addend,
	input  logic [4:0]  target_day,
	input  logic [3:0]  target_month,
	input  logic [13:0] target_year,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  out_day,
	output int          fail_count,
	output int          pending,
	input  logic [3:0]  out_month,
	input  logic [13:0] out_year,
	input  logic [21:0] day_count,
	input  logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [13:0] cfg_data
);
	import cda_pkg::*;
	import date_op_pkg::*;

	localparam int unsigned MONTHS_PER_YEAR = 12;

	typedef struct {
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [21:0] cnt;
		logic [1:0]  st;
	} date_result_t;

	logic [13:0]  lo_year;
	logic [13:0]  hi_year;
	date_result_t expected_q[$];
	date_result_t oldest;
	int           mismatches = 0;

	assign fail_count = mismatches;

	function automatic bit leap_year(int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic bit date_in_range(int unsigned d, int unsigned m, int unsigned y);
		if (m < 1 || m > MONTHS_PER_YEAR)
			return 1'b0;
		if (d < 1 || d > month_days(m, y))
			return 1'b0;
		return (y >= lo_year) && (y <= hi_year);
	endfunction

	// days since a fixed origin; the year is shifted by one era so it never goes negative
	function automatic int unsigned day_serial(int unsigned d, int unsigned m, int unsigned y);
		int unsigned past;
		int unsigned s;
		past = y + 399;
		s = past * 365 + past / 4 - past / 100 + past / 400 + d;
		for (int unsigned k = 1; k < m; k++)
			s += month_days(k, y);
		return s;
	endfunction

	function automatic date_result_t predict_result(date_op_t o, logic [4:0] d,
			logic [3:0] m, logic [13:0] y, logic [15:0] a, logic [4:0] td,
			logic [3:0] tm, logic [13:0] ty);
		date_result_t r;
		int unsigned left;
		int unsigned nm;
		int unsigned ny;
		int unsigned from_day;
		int unsigned to_day;
		r = '{d, m, y, 22'd0, ST_OK};
		if (!date_in_range(d, m, y)) begin
			r.st = ST_BAD;
		end else if (o == OP_ADD_DAYS) begin
			// walk forward month by month until the day fits
			left = 32'(a) + 32'(d);
			nm = 32'(m);
			ny = 32'(y);
			while (left > month_days(nm, ny)) begin
				left -= month_days(nm, ny);
				if (nm == MONTHS_PER_YEAR) begin
					nm = 1;
					ny++;
				end else begin
					nm++;
				end
			end
			if (ny < lo_year)
				ny = 32'(lo_year);
			if (ny > hi_year) begin
				r.st = ST_OVF;
			end else begin
				r.d = 5'(left);
				r.m = 4'(nm);
				r.y = 14'(ny);
			end
		end else if (!date_in_range(td, tm, ty)) begin
			r.st = ST_BAD;
		end else begin
			from_day = day_serial(d, m, y);
			to_day = day_serial(td, tm, ty);
			r.cnt = 22'((to_day > from_day) ? to_day - from_day : 0);
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_year <= MIN_YEAR_RST;
			hi_year <= MAX_YEAR_RST;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_YEAR)
					lo_year <= cfg_data;
				else
					hi_year <= cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d/%0d count %0d status %0d with no request",
						out_day, out_month, out_year, day_count, status));
				end else begin
					oldest = expected_q.pop_front();
					if (out_day !== oldest.d)
						report_mismatch($sformatf("out_day %0d, want %0d", out_day, oldest.d));
					if (out_month !== oldest.m)
						report_mismatch($sformatf("out_month %0d, want %0d", out_month, oldest.m));
					if (out_year !== oldest.y)
						report_mismatch($sformatf("out_year %0d, want %0d", out_year, oldest.y));
					if (day_count !== oldest.cnt)
						report_mismatch($sformatf("day_count %0d, want %0d", day_count, oldest.cnt));
					if (status !== oldest.st)
						report_mismatch($sformatf("status %0d, want %0d", status, oldest.st));
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_result(date_op_t'(op), day, month, year, addend,
					target_day, target_month, target_year));
			pending <= expected_q.size();
		end
	end

endmodule

// ===== dv/calendar_date_add_and_difference_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_and_difference_test: date unit testbench
// Directed edge dates then random add and count requests over several year
// limits and flow-control mixes; a side checker scores every result.
// ----------------------------------------------------------------------------
module calendar_date_add_and_difference_test;
	import cda_pkg::*;
	import date_op_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 1500;
	localparam int PHASE_ITEMS   = 29;
	localparam int NEAR_TOP      = 180;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = 1'b0;
	logic [4:0]  day = '0;
	logic [3:0]  month = '0;
	logic [13:0] year = '0;
	logic [15:0] addend = '0;
	logic [4:0]  target_day = '0;
	logic [3:0]  target_month = '0;
	logic [13:0] target_year = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [13:0] out_year;
	logic [21:0] day_count;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_MIN_YEAR;
	logic [13:0] cfg_data = '0;
	int          fail_count;
	int          pending;

	int idle_pct = 0;
	int stall_pct = 0;
	int cur_lo = int'(MIN_YEAR_RST);
	int cur_hi = int'(MAX_YEAR_RST);
	int cycles = 0;

	calendar_date_add_and_difference u_top (.*);

	calendar_date_add_and_difference_checker u_checker (.*);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("calendar_date_add_and_difference_test: errors");
			$finish;
		end
	end

	// valid stays up across back-to-back transfers; it drops during an idle cycle and while waiting for results
	task automatic push_item(date_op_t o, int d, int m, int y, int a,
			int td, int tm, int ty);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		day <= 5'(d);
		month <= 4'(m);
		year <= 14'(y);
		addend <= 16'(a);
		target_day <= 5'(td);
		target_month <= 4'(tm);
		target_year <= 14'(ty);
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_year_limits(int lo, int hi);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_YEAR;
		cfg_data <= 14'(lo);
		@(posedge clk);
		cfg_index <= CFG_MAX_YEAR;
		cfg_data <= 14'(hi);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	task automatic push_random();
		date_op_t o;
		int d, m, y, a, td, tm, ty;
		o = date_op_t'($urandom_range(1));
		if ($urandom_range(99) < 10) begin
			// raw noise across the whole field ranges
			push_item(o, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			m = $urandom_range(12, 1);
			d = ($urandom_range(99) < 85) ? $urandom_range(28, 1) : $urandom_range(31, 29);
			if (o == OP_ADD_DAYS && cur_hi > NEAR_TOP && $urandom_range(99) < 20)
				y = cur_hi - $urandom_range(NEAR_TOP);
			else
				y = $urandom_range(cur_hi, cur_lo);
			a = ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(500);
			tm = $urandom_range(12, 1);
			td = ($urandom_range(99) < 85) ? $urandom_range(28, 1) : $urandom_range(31, 29);
			if ($urandom_range(1) == 0) begin
				// near the start so earlier, equal and later targets all occur
				ty = y + $urandom_range(4) - 2;
				if ($urandom_range(3) == 0) begin
					tm = m;
					td = d + $urandom_range(2) - 1;
				end
			end else begin
				ty = $urandom_range(cur_hi, cur_lo);
			end
			push_item(o, d, m, y, a, td, tm, ty);
		end
	endtask

	initial begin
		int phase_lo[4];
		int phase_hi[4];
		int phase_idle[4];
		int phase_stall[4];
		int lo;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits 1980 to 9999
		push_item(OP_ADD_DAYS, 1, 1, 1980, 0, 0, 0, 0);
		push_item(OP_ADD_DAYS, 31, 12, 9999, 65535, 0, 0, 0);
		push_item(OP_ADD_DAYS, 1, 1, 1980, 65535, 0, 0, 0);
		push_item(OP_ADD_DAYS, 28, 2, 2000, 1, 0, 0, 0);
		push_item(OP_ADD_DAYS, 28, 2, 2100, 1, 0, 0, 0);
		push_item(OP_ADD_DAYS, 31, 12, 2023, 1, 0, 0, 0);
		push_item(OP_ADD_DAYS, 29, 2, 2024, 1, 0, 0, 0);
		push_item(OP_ADD_DAYS, 0, 5, 2000, 3, 0, 0, 0);
		push_item(OP_ADD_DAYS, 31, 4, 2001, 3, 0, 0, 0);
		push_item(OP_ADD_DAYS, 29, 2, 2023, 3, 0, 0, 0);
		push_item(OP_COUNT_DAYS, 31, 13, 2000, 0, 1, 1, 2001);
		push_item(OP_COUNT_DAYS, 1, 15, 16383, 0, 1, 1, 2001);
		push_item(OP_ADD_DAYS, 15, 6, 1979, 10, 0, 0, 0);
		push_item(OP_COUNT_DAYS, 1, 1, 1980, 0, 31, 12, 9999);
		push_item(OP_COUNT_DAYS, 10, 10, 2010, 0, 9, 10, 2010);
		push_item(OP_COUNT_DAYS, 10, 10, 2010, 0, 10, 10, 2010);
		push_item(OP_COUNT_DAYS, 1, 1, 2000, 0, 1, 0, 2001);
		push_item(OP_COUNT_DAYS, 28, 2, 2000, 0, 1, 3, 2000);

		wait_all_results();
		set_year_limits(1, 9999);
		push_item(OP_ADD_DAYS, 1, 1, 0, 0, 0, 0, 0);
		push_item(OP_COUNT_DAYS, 1, 1, 1, 0, 1, 1, 9999);
		push_item(OP_ADD_DAYS, 1, 1, 1, 365, 0, 0, 0);

		// crossed limits reject every date
		wait_all_results();
		set_year_limits(6200, 4000);
		push_item(OP_ADD_DAYS, 1, 1, 5000, 1, 0, 0, 0);
		push_item(OP_COUNT_DAYS, 1, 1, 4000, 0, 1, 1, 4001);

		wait_all_results();
		set_year_limits(9999, 9999);
		push_item(OP_ADD_DAYS, 31, 12, 9999, 1, 0, 0, 0);
		push_item(OP_COUNT_DAYS, 1, 1, 9999, 0, 31, 12, 9999);

		lo = $urandom_range(9999, 1);
		phase_lo = '{1, 1980, 1900, lo};
		phase_hi = '{9999, 9999, 2100, $urandom_range(9999, lo)};
		phase_idle = '{0, 50, 0, 15};
		phase_stall = '{0, 0, 50, 15};
		for (int p = 0; p < 4; p++) begin
			wait_all_results();
			set_year_limits(phase_lo[p], phase_hi[p]);
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_random();
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("calendar_date_add_and_difference_test: clean");
		else
			$display("calendar_date_add_and_difference_test: errors");
		$finish;
	end

endmodule
